### rtl/core/obd_pkg.sv
// ----------------------------------------------------------------------------
// obd_pkg
// Shared widths, register indexes and the stage control word of the
// occupancy block-OR downsampler.
// ----------------------------------------------------------------------------
package obd_pkg;

    localparam int PIX_W      = 8;   // pixel sample width
    localparam int CELL_W     = 10;  // cell index width on the result port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_REG_W  = 11;  // image_width / image_height registers
    localparam int SIDE_REG_W = 7;   // cell_side register

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE    = 2'd2;

    localparam logic [DIM_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_REG_W-1:0]  RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [SIDE_REG_W-1:0] RST_CELL_SIDE    = 7'd8;

    // Per-pixel control carried from the input register to the combine stage.
    typedef struct packed {
        logic pix;       // sample is nonzero
        logic in_crop;   // pixel lies inside the cropped grid
        logic ox_first;  // first column of its cell
        logic oy_first;  // first row of its cell
        logic ox_last;   // last column of its cell
        logic oy_last;   // last row of its cell
        logic last;      // pixel belongs to the final cell of the grid
    } t_cell_ctl;

endpackage

### rtl/core/obd_pix_if.sv
// ----------------------------------------------------------------------------
// obd_pix_if
// Valid/ready channel carrying one occupancy pixel per word.
// ----------------------------------------------------------------------------
interface obd_pix_if;
    logic                       valid;
    logic                       ready;
    logic [obd_pkg::PIX_W-1:0]  pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

### rtl/core/obd_cell_if.sv
// ----------------------------------------------------------------------------
// obd_cell_if
// Valid/ready channel carrying one finished grid cell per word.
// ----------------------------------------------------------------------------
interface obd_cell_if;
    logic                        valid;
    logic                        ready;
    logic [obd_pkg::CELL_W-1:0]  cell_x;
    logic [obd_pkg::CELL_W-1:0]  cell_y;
    logic                        occupied;
    logic                        last_cell;

    modport source (output valid, output cell_x, output cell_y, output occupied,
                    output last_cell, input ready);
    modport sink   (input valid, input cell_x, input cell_y, input occupied,
                    input last_cell, output ready);
endinterface

### rtl/core/obd_geom.sv
// ----------------------------------------------------------------------------
// obd_geom
// Grid geometry unit: clamps the registers and works out, per axis, the
// number of cells and the first cropped pixel with a bit-serial divider.
// ----------------------------------------------------------------------------
module obd_geom #(
    parameter int MAX_IMAGE_DIM = 1024,
    parameter int MAX_CELL_SIDE = 64,
    localparam int DW     = $clog2(MAX_IMAGE_DIM + 1),
    localparam int SIDE_W = $clog2(MAX_CELL_SIDE + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [obd_pkg::DIM_REG_W-1:0]     i_width,
    input  logic [obd_pkg::DIM_REG_W-1:0]     i_height,
    input  logic [obd_pkg::SIDE_REG_W-1:0]    i_side,
    output logic                              o_busy,
    output logic [DW-1:0]                     o_w,
    output logic [DW-1:0]                     o_h,
    output logic [SIDE_W-1:0]                 o_side,
    output logic [SIDE_W-1:0]                 o_xs,
    output logic [DW-1:0]                     o_gx,
    output logic [SIDE_W-1:0]                 o_ys,
    output logic [DW-1:0]                     o_gy
);

    localparam int CNT_W = $clog2(DW);
    localparam logic G_IDLE = 1'b0;
    localparam logic G_DIV  = 1'b1;

    logic              r_state, n_state;
    logic              r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DW-1:0]     r_num, n_num;
    logic [DW-1:0]     r_q, n_q;
    logic [SIDE_W-1:0] r_rem, n_rem;
    logic [DW-1:0]     r_w, n_w, r_h, n_h;
    logic [SIDE_W-1:0] r_side, n_side;
    logic [SIDE_W-1:0] r_xs, n_xs, r_ys, n_ys;
    logic [DW-1:0]     r_gx, n_gx, r_gy, n_gy;

    logic [DW-1:0]     w_clamp, h_clamp;
    logic [SIDE_W-1:0] side_clamp;
    logic [SIDE_W:0]   trial, trial_sub, wrem, wrem_sub;
    logic              ge, wge, wmod_nz, dim_bit;
    logic [SIDE_W-1:0] rem_n, start_n;
    logic [DW-1:0]     q_n, cells_n;

    always_comb begin
        if (i_width == '0) begin
            w_clamp = DW'(1);
        end else if (32'(i_width) > 32'(MAX_IMAGE_DIM)) begin
            w_clamp = DW'(MAX_IMAGE_DIM);
        end else begin
            w_clamp = DW'(i_width);
        end
        if (i_height == '0) begin
            h_clamp = DW'(1);
        end else if (32'(i_height) > 32'(MAX_IMAGE_DIM)) begin
            h_clamp = DW'(MAX_IMAGE_DIM);
        end else begin
            h_clamp = DW'(i_height);
        end
        if (i_side == '0) begin
            side_clamp = SIDE_W'(1);
        end else if (32'(i_side) > 32'(MAX_CELL_SIDE)) begin
            side_clamp = SIDE_W'(MAX_CELL_SIDE);
        end else begin
            side_clamp = SIDE_W'(i_side);
        end
    end

    // One restoring division step per cycle on half the dimension.
    always_comb begin
        trial     = {r_rem, r_num[DW-1]};
        trial_sub = trial - {1'b0, r_side};
        ge        = trial >= {1'b0, r_side};
        rem_n     = ge ? trial_sub[SIDE_W-1:0] : trial[SIDE_W-1:0];
        q_n       = {r_q[DW-2:0], ge};
        cells_n   = {q_n[DW-2:0], 1'b0};
        // dim mod side follows from 2*(half mod side) plus the dropped bit.
        dim_bit   = r_axis ? r_h[0] : r_w[0];
        wrem      = {rem_n, dim_bit};
        wrem_sub  = wrem - {1'b0, r_side};
        wge       = wrem >= {1'b0, r_side};
        wmod_nz   = wge ? (wrem_sub != '0) : (wrem != '0);
        start_n   = wmod_nz ? rem_n : '0;
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_q     = r_q;
        n_rem   = r_rem;
        n_w     = r_w;
        n_h     = r_h;
        n_side  = r_side;
        n_xs    = r_xs;
        n_gx    = r_gx;
        n_ys    = r_ys;
        n_gy    = r_gy;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_state = G_DIV;
                    n_axis  = 1'b0;
                    n_cnt   = CNT_W'(DW - 1);
                    n_num   = w_clamp >> 1;
                    n_q     = '0;
                    n_rem   = '0;
                    n_w     = w_clamp;
                    n_h     = h_clamp;
                    n_side  = side_clamp;
                end
            end
            G_DIV: begin
                n_num = r_num << 1;
                n_q   = q_n;
                n_rem = rem_n;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (!r_axis) begin
                        n_xs   = start_n;
                        n_gx   = cells_n;
                        n_axis = 1'b1;
                        n_cnt  = CNT_W'(DW - 1);
                        n_num  = r_h >> 1;
                        n_q    = '0;
                        n_rem  = '0;
                    end else begin
                        n_ys    = start_n;
                        n_gy    = cells_n;
                        n_state = G_IDLE;
                    end
                end
            end
            default: n_state = G_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_axis <= n_axis;
        r_cnt  <= n_cnt;
        r_num  <= n_num;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_w    <= n_w;
        r_h    <= n_h;
        r_side <= n_side;
        r_xs   <= n_xs;
        r_gx   <= n_gx;
        r_ys   <= n_ys;
        r_gy   <= n_gy;
    end

    assign o_busy = (r_state != G_IDLE);
    assign o_w    = r_w;
    assign o_h    = r_h;
    assign o_side = r_side;
    assign o_xs   = r_xs;
    assign o_gx   = r_gx;
    assign o_ys   = r_ys;
    assign o_gy   = r_gy;

endmodule

### rtl/core/occupancy_block_or_downsampler_core.sv
// ----------------------------------------------------------------------------
// occupancy_block_or_downsampler_core
// Reduces a raster occupancy image to a grid of square cells by block OR.
// ----------------------------------------------------------------------------
// Usage: pixels enter one word per cycle in raster order and a finished cell
// passes the input and output registers after its bottom-right pixel is
// taken; the sustained rate without stalls is one pixel per cycle, set by the
// single read and single write a cycle on the per-column OR store. After
// reset and after every write to image_width, image_height or cell_side the
// grid geometry is recomputed by a bit-serial divider, one quotient bit per
// cycle for each axis, and the frame restarts; input ready stays low
// meanwhile. Configuration is to be written only while the block is idle.
// Results appear in raster order of cells, the last cell flagged.
// ----------------------------------------------------------------------------
module occupancy_block_or_downsampler_core #(
    parameter int MAX_IMAGE_DIM = 1024,
    parameter int MAX_CELL_SIDE = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [obd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [obd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    obd_pix_if.sink                            i_pix,
    obd_cell_if.source                         o_cell
);

    localparam int DW     = $clog2(MAX_IMAGE_DIM + 1);
    localparam int AW     = $clog2(MAX_IMAGE_DIM);
    localparam int SIDE_W = $clog2(MAX_CELL_SIDE + 1);
    localparam int CMP_W  = (DW > SIDE_W) ? DW : SIDE_W;

    // Configuration registers and frame restart.
    logic [obd_pkg::DIM_REG_W-1:0]  r_cfg_width, r_cfg_height;
    logic [obd_pkg::SIDE_REG_W-1:0] r_cfg_side;
    logic                           r_restart;
    logic                           cfg_hit;

    always_comb begin
        unique case (i_cfg_idx)
            obd_pkg::CFG_IMAGE_WIDTH,
            obd_pkg::CFG_IMAGE_HEIGHT,
            obd_pkg::CFG_CELL_SIDE: cfg_hit = i_cfg_we;
            default:                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= obd_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= obd_pkg::RST_IMAGE_HEIGHT;
            r_cfg_side   <= obd_pkg::RST_CELL_SIDE;
            r_restart    <= 1'b1;
        end else begin
            r_restart <= cfg_hit;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    obd_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                    obd_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                    obd_pkg::CFG_CELL_SIDE:
                        r_cfg_side <= i_cfg_data[obd_pkg::SIDE_REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Grid geometry.
    logic              geom_busy;
    logic [DW-1:0]     w, h, gx, gy;
    logic [SIDE_W-1:0] side, xs, ys;

    obd_geom #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .MAX_CELL_SIDE (MAX_CELL_SIDE)
    ) u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_restart),
        .i_width  (r_cfg_width),
        .i_height (r_cfg_height),
        .i_side   (r_cfg_side),
        .o_busy   (geom_busy),
        .o_w      (w),
        .o_h      (h),
        .o_side   (side),
        .o_xs     (xs),
        .o_gx     (gx),
        .o_ys     (ys),
        .o_gy     (gy)
    );

    logic busy;
    assign busy = r_restart || geom_busy;

    // Position counters: pixel position, offset in the cell and cell index.
    logic [DW-1:0]     r_col, n_col, r_row, n_row;
    logic [SIDE_W-1:0] r_ox, n_ox, r_oy, n_oy;
    logic [DW-1:0]     r_cx, n_cx, r_cy, n_cy;
    logic              col_in, row_in, col_last, row_last, ox_last, oy_last;
    logic              pix_acc;

    assign col_in   = CMP_W'(r_col) >= CMP_W'(xs);
    assign row_in   = CMP_W'(r_row) >= CMP_W'(ys);
    assign col_last = (r_col == w - DW'(1));
    assign row_last = (r_row == h - DW'(1));
    assign ox_last  = (r_ox == side - SIDE_W'(1));
    assign oy_last  = (r_oy == side - SIDE_W'(1));
    assign pix_acc  = i_pix.valid && i_pix.ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        n_cx  = r_cx;
        n_cy  = r_cy;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
            n_ox  = '0;
            n_oy  = '0;
            n_cx  = '0;
            n_cy  = '0;
        end else if (pix_acc) begin
            if (col_last) begin
                n_col = '0;
                n_ox  = '0;
                n_cx  = '0;
                if (row_last) begin
                    n_row = '0;
                    n_oy  = '0;
                    n_cy  = '0;
                end else begin
                    n_row = r_row + DW'(1);
                    if (row_in) begin
                        if (oy_last) begin
                            n_oy = '0;
                            n_cy = r_cy + DW'(1);
                        end else begin
                            n_oy = r_oy + SIDE_W'(1);
                        end
                    end
                end
            end else begin
                n_col = r_col + DW'(1);
                if (col_in) begin
                    if (ox_last) begin
                        n_ox = '0;
                        n_cx = r_cx + DW'(1);
                    end else begin
                        n_ox = r_ox + SIDE_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
        end
    end

    // Input register: control word, cell index and the column flag read.
    obd_pkg::t_cell_ctl in_ctl, r_s1_ctl;
    logic               r_s1_v;
    logic [DW-1:0]      r_s1_cx, r_s1_cy;
    logic               r_s1_flag;
    logic               r_flags [MAX_IMAGE_DIM];

    always_comb begin
        in_ctl.pix      = (i_pix.pixel_value != '0);
        in_ctl.in_crop  = col_in && row_in && (r_cx < gx) && (r_cy < gy);
        in_ctl.ox_first = (r_ox == '0);
        in_ctl.oy_first = (r_oy == '0);
        in_ctl.ox_last  = ox_last;
        in_ctl.oy_last  = oy_last;
        in_ctl.last     = (r_cx == gx - DW'(1)) && (r_cy == gy - DW'(1));
    end

    // Combine stage.
    logic emit, s1_go, base, acc_new, r_acc;
    logic r_out_v;

    assign emit    = r_s1_ctl.in_crop && r_s1_ctl.ox_last && r_s1_ctl.oy_last;
    assign s1_go   = r_s1_v && (!emit || !r_out_v || o_cell.ready);
    assign base    = r_s1_ctl.oy_first ? 1'b0 : r_s1_flag;
    assign acc_new = r_s1_ctl.ox_first ? (base | r_s1_ctl.pix)
                                       : (r_acc | r_s1_ctl.pix);

    assign i_pix.ready = !busy && (!r_s1_v || s1_go);

    // The flag of a column is written when a cell row segment ends and read
    // again only a full image row later, so reads never meet pending writes.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_flag <= r_flags[r_cx[AW-1:0]];
        end
        if (s1_go && r_s1_ctl.in_crop && r_s1_ctl.ox_last) begin
            r_flags[r_s1_cx[AW-1:0]] <= acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (cfg_hit) begin
            r_s1_v <= 1'b0;
        end else if (pix_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
        if (pix_acc) begin
            r_s1_ctl <= in_ctl;
            r_s1_cx  <= r_cx;
            r_s1_cy  <= r_cy;
        end
        if (s1_go && r_s1_ctl.in_crop) begin
            r_acc <= acc_new;
        end
    end

    // Output register.
    logic [obd_pkg::CELL_W-1:0] r_out_x, r_out_y;
    logic                       r_out_occ, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_go && emit) begin
            r_out_v <= 1'b1;
        end else if (o_cell.ready) begin
            r_out_v <= 1'b0;
        end
        if (s1_go && emit) begin
            r_out_x    <= obd_pkg::CELL_W'(r_s1_cx);
            r_out_y    <= obd_pkg::CELL_W'(r_s1_cy);
            r_out_occ  <= acc_new;
            r_out_last <= r_s1_ctl.last;
        end
    end

    assign o_cell.valid     = r_out_v;
    assign o_cell.cell_x    = r_out_x;
    assign o_cell.cell_y    = r_out_y;
    assign o_cell.occupied  = r_out_occ;
    assign o_cell.last_cell = r_out_last;

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !i_pix.ready)
        else $error("pixel accepted while the grid geometry is being computed");

    a_offsets_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_ox < side) && (r_oy < side))
        else $error("cell offset counter ran past the cell side");

    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && emit && r_s1_ctl.last) |=>
            (o_cell.cell_x == obd_pkg::CELL_W'(gx - DW'(1))) &&
            (o_cell.cell_y == obd_pkg::CELL_W'(gy - DW'(1))))
        else $error("last cell flag on a cell that is not the grid corner");
`endif

endmodule

### tb/obd_cell_checker.sv
// ----------------------------------------------------------------------------
// obd_cell_checker
// Watches the configuration port and both channels of the occupancy
// downsampler. It keeps its own model of the crop geometry, the raster
// position and the per-column OR flags, works out each cell word that an
// accepted pixel completes and compares each accepted cell word with the
// oldest one still outstanding.
// ----------------------------------------------------------------------------
module obd_cell_checker #(
    parameter int MAX_IMAGE_DIM = 1024,
    parameter int MAX_CELL_SIDE = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [obd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [obd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_pix_valid,
    input  logic                             i_pix_ready,
    input  logic [obd_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                             i_cell_valid,
    input  logic                             i_cell_ready,
    input  logic [obd_pkg::CELL_W-1:0]       i_cell_x,
    input  logic [obd_pkg::CELL_W-1:0]       i_cell_y,
    input  logic                             i_occupied,
    input  logic                             i_last_cell,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_cells_checked,
    output int                               o_frame_ends
);

    typedef struct packed {
        logic [obd_pkg::CELL_W-1:0] cell_x;
        logic [obd_pkg::CELL_W-1:0] cell_y;
        logic                       occupied;
        logic                       last_cell;
    } t_cell_word;

    logic [obd_pkg::DIM_REG_W-1:0]  width_reg;
    logic [obd_pkg::DIM_REG_W-1:0]  height_reg;
    logic [obd_pkg::SIDE_REG_W-1:0] side_reg;
    int unsigned                    pix_col;
    int unsigned                    pix_row;
    logic [MAX_IMAGE_DIM-1:0]       col_or;
    t_cell_word                     expected_cells[$];
    int                             fail_count = 0;
    int                             cells_checked = 0;
    int                             frame_ends = 0;

    assign o_fail_count    = fail_count;
    assign o_cells_checked = cells_checked;
    assign o_frame_ends    = frame_ends;

    function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Number of cells along one axis and the first pixel inside the crop.
    function automatic void axis_geometry(input int unsigned dim, input int unsigned side,
                                          output int unsigned cells,
                                          output int unsigned start);
        cells = ((dim / 2) / side) * 2;
        start = (dim % side != 0) ? ((dim / 2) % side) : 0;
    endfunction

    task automatic restart_frame();
        pix_col = 0;
        pix_row = 0;
        col_or  = '0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic predict_cell(input logic [obd_pkg::PIX_W-1:0] value);
        int unsigned w, h, side, gx, gy, xs, ys, rx, ry, cx, cy, ox, oy;
        logic        occ;
        t_cell_word  word;
        w    = clamp_reg(32'(width_reg), MAX_IMAGE_DIM);
        h    = clamp_reg(32'(height_reg), MAX_IMAGE_DIM);
        side = clamp_reg(32'(side_reg), MAX_CELL_SIDE);
        occ  = (value != '0);
        axis_geometry(w, side, gx, xs);
        axis_geometry(h, side, gy, ys);
        if (pix_col >= xs && pix_col < xs + gx * side &&
            pix_row >= ys && pix_row < ys + gy * side) begin
            rx = pix_col - xs;
            ry = pix_row - ys;
            cx = rx / side;
            cy = ry / side;
            ox = rx % side;
            oy = ry % side;
            // The first pixel of a cell loads the column flag, so every block
            // row starts from a clear flag.
            if (ox == 0 && oy == 0) begin
                col_or[cx] = occ;
            end else if (occ) begin
                col_or[cx] = 1'b1;
            end
            if (ox == side - 1 && oy == side - 1) begin
                word.cell_x    = obd_pkg::CELL_W'(cx);
                word.cell_y    = obd_pkg::CELL_W'(cy);
                word.occupied  = col_or[cx];
                word.last_cell = (cx == gx - 1 && cy == gy - 1);
                expected_cells.push_back(word);
            end
        end
        pix_col++;
        if (pix_col >= w) begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= h) pix_row = 0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_cell_word want;
        if (!i_rst_n) begin
            width_reg  = obd_pkg::RST_IMAGE_WIDTH;
            height_reg = obd_pkg::RST_IMAGE_HEIGHT;
            side_reg   = obd_pkg::RST_CELL_SIDE;
            restart_frame();
            expected_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    obd_pkg::CFG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[obd_pkg::DIM_REG_W-1:0];
                        restart_frame();
                    end
                    obd_pkg::CFG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[obd_pkg::DIM_REG_W-1:0];
                        restart_frame();
                    end
                    obd_pkg::CFG_CELL_SIDE: begin
                        side_reg = i_cfg_data[obd_pkg::SIDE_REG_W-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (i_pix_valid && i_pix_ready) predict_cell(i_pixel_value);
            if (i_cell_valid && i_cell_ready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected cell word x=%0d y=%0d",
                                              i_cell_x, i_cell_y));
                end else begin
                    want = expected_cells.pop_front();
                    cells_checked++;
                    if (want.last_cell) frame_ends++;
                    if (i_cell_x !== want.cell_x)
                        report_mismatch($sformatf("cell_x got %0d want %0d",
                                                  i_cell_x, want.cell_x));
                    if (i_cell_y !== want.cell_y)
                        report_mismatch($sformatf("cell_y got %0d want %0d (x=%0d)",
                                                  i_cell_y, want.cell_y, want.cell_x));
                    if (i_occupied !== want.occupied)
                        report_mismatch($sformatf("occupied got %b want %b at x=%0d y=%0d",
                                                  i_occupied, want.occupied,
                                                  want.cell_x, want.cell_y));
                    if (i_last_cell !== want.last_cell)
                        report_mismatch($sformatf("last_cell got %b want %b at x=%0d y=%0d",
                                                  i_last_cell, want.last_cell,
                                                  want.cell_x, want.cell_y));
                end
            end
        end
        o_pending <= expected_cells.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the occupancy downsampler with directed and random pixel streams
// over many grid geometries, including clamped register values, empty grids,
// cropped edges and frame wrap-round, with random stalls on both channels and
// a long output stall. The checker beside the block predicts every cell word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_IMAGE_DIM = 1024;
    localparam int MAX_CELL_SIDE = 64;
    localparam int PIXEL_BUDGET  = 1150;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;
    // Geometry recalculation after reset or a register write, plus margin.
    localparam int SETUP_CYCLES  = 2 * $clog2(MAX_IMAGE_DIM + 1) + 2 + 8;
    localparam int RUN_LIMIT     = 1_600_000;

    // Directed frame of a 4x4 image in 2x2 cells, then the top of the next frame.
    localparam logic [24*obd_pkg::PIX_W-1:0] DIRECTED_PIXELS = {
        8'd0,  8'd255, 8'd1,  8'd2,
        8'd4,  8'd8,   8'd16, 8'd32,
        8'd64, 8'd128, 8'd0,  8'd0,
        8'd0,  8'd0,   8'd0,  8'd0,
        8'd0,  8'd0,   8'd0,  8'd0,
        8'd0,  8'd0,   8'd0,  8'd0
    };

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [obd_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [obd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           long_hold = 1'b0;
    int                             dst_idle_pct = 0;
    int                             src_idle_pct = 0;
    int                             hold_left = 0;
    int                             pixels_sent = 0;
    int                             geometries = 0;
    int                             fail_count;
    int                             pending;
    int                             cells_checked;
    int                             frame_ends;

    obd_pix_if  pix_ch();
    obd_cell_if cell_ch();

    always #2 clk = ~clk;

    occupancy_block_or_downsampler_core #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .MAX_CELL_SIDE (MAX_CELL_SIDE)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch),
        .o_cell     (cell_ch)
    );

    obd_cell_checker #(
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
        .MAX_CELL_SIDE (MAX_CELL_SIDE)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_pix_valid     (pix_ch.valid),
        .i_pix_ready     (pix_ch.ready),
        .i_pixel_value   (pix_ch.pixel_value),
        .i_cell_valid    (cell_ch.valid),
        .i_cell_ready    (cell_ch.ready),
        .i_cell_x        (cell_ch.cell_x),
        .i_cell_y        (cell_ch.cell_y),
        .i_occupied      (cell_ch.occupied),
        .i_last_cell     (cell_ch.last_cell),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_cells_checked (cells_checked),
        .o_frame_ends    (frame_ends)
    );

    // Cell receiver: random stalls, or a long hold-off when asked for one.
    always @(posedge clk) begin
        if (!rst_n) begin
            cell_ch.ready <= 1'b0;
            hold_left     <= 0;
        end else if (long_hold) begin
            cell_ch.ready <= 1'b0;
            hold_left     <= LONG_HOLD;
        end else if (hold_left != 0) begin
            cell_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            cell_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    task automatic write_reg(input logic [obd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [obd_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        repeat (SETUP_CYCLES) @(posedge clk);
    endtask

    task automatic write_geometry(input logic [obd_pkg::DIM_REG_W-1:0] w,
                                  input logic [obd_pkg::DIM_REG_W-1:0] h,
                                  input logic [obd_pkg::SIDE_REG_W-1:0] side);
        write_reg(obd_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(obd_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(obd_pkg::CFG_CELL_SIDE, obd_pkg::CFG_DATA_W'(side));
        geometries++;
    endtask

    task automatic send_pixel(input logic [obd_pkg::PIX_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= value;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        pixels_sent++;
    endtask

    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // The run goes through three idling regimes by progress through the pixels.
    task automatic pick_idle_mode();
        if (pixels_sent < PIXEL_BUDGET / 3) begin
            src_idle_pct = 21;
            dst_idle_pct <= 77;
        end else if (pixels_sent < 2 * PIXEL_BUDGET / 3) begin
            src_idle_pct = 77;
            dst_idle_pct <= 21;
        end else begin
            src_idle_pct = 0;
            dst_idle_pct <= 0;
        end
    endtask

    task automatic run_phase(input logic [obd_pkg::DIM_REG_W-1:0] w,
                             input logic [obd_pkg::DIM_REG_W-1:0] h,
                             input logic [obd_pkg::SIDE_REG_W-1:0] side, input int count,
                             input int density, input bit hold);
        logic [obd_pkg::PIX_W-1:0] value;
        pick_idle_mode();
        if (hold) src_idle_pct = 0;
        write_geometry(w, h, side);
        if (hold) long_hold <= 1'b1;
        for (int k = 0; k < count; k++) begin
            // Now and then the sender waits mid-frame for every cell to drain.
            if (k == count / 2 && (hold || $urandom_range(3) == 0)) drain_results();
            if ($urandom_range(19) == 0)
                value = obd_pkg::PIX_W'($urandom_range(255));
            else if ($urandom_range(99) < density)
                value = obd_pkg::PIX_W'($urandom_range(255, 1));
            else
                value = '0;
            send_pixel(value);
            if (hold && k == 0) long_hold <= 1'b0;
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int w, h, side, count, density;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= obd_pkg::CFG_IMAGE_WIDTH;
        cfg_data           <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETUP_CYCLES) @(posedge clk);

        // Directed: every single-bit value, one free cell, a frame wrap and a block
        // row start whose column flag was set in the previous frame.
        pick_idle_mode();
        write_geometry(11'd4, 11'd4, 7'd2);
        for (int k = 0; k < 24; k++)
            send_pixel(DIRECTED_PIXELS[(23 - k) * obd_pkg::PIX_W +: obd_pkg::PIX_W]);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Register corners: zeros clamp to one (empty grid), oversized values
        // clamp to the maximum, the reset geometry and the widest single-pixel grid.
        run_phase(11'd0, 11'd0, 7'd0, 30, 50, 1'b0);
        run_phase(11'd2047, 11'd2, 7'd0, 90, 30, 1'b0);
        run_phase(11'd1024, 11'd1024, 7'd8, 40, 30, 1'b0);
        run_phase(11'd5, 11'd5, 7'd127, 30, 30, 1'b0);
        run_phase(11'd2047, 11'd2047, 7'd127, 20, 30, 1'b0);
        run_phase(11'd1, 11'd1024, 7'd64, 12, 30, 1'b0);
        // One word per pixel while the receiver holds off, so the block backs up.
        run_phase(11'd8, 11'd8, 7'd1, 80, 40, 1'b1);

        while (pixels_sent < PIXEL_BUDGET) begin
            w     = $urandom_range(20, 1);
            h     = $urandom_range(20, 1);
            side  = $urandom_range(5, 1);
            count = w * h + $urandom_range(w * h);
            if (count < 16) count = 16;
            if (count > 150) count = 150;
            case ($urandom_range(3))
                0:       density = 0;
                1:       density = 3;
                2:       density = 15;
                default: density = 60;
            endcase
            run_phase(obd_pkg::DIM_REG_W'(w), obd_pkg::DIM_REG_W'(h),
                      obd_pkg::SIDE_REG_W'(side), count, density, 1'b0);
        end

        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d pixels over %0d geometries, clamped and empty grids included.",
                 pixels_sent, geometries);
        $display("Compared %0d cell words, %0d of them closing a frame.",
                 cells_checked, frame_ends);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Run limit reached with %0d cell words outstanding.", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
